[hdl/bbfci_pkg.sv]
// Package for the boot-block flash command interface.
// Holds the item types, command codes, block tables and ID helpers.
// Used by every module of the block but bbfci_ram; depends on nothing.
`default_nettype none

package bbfci_pkg;

  localparam int ADDR_W = 18;
  localparam int ARRAY_BYTES_DEFAULT = 262144;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  localparam logic [1:0] KIND_NOP = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_PRELOAD = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_WORD_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_A16 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_BOOT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TWO_MEGABIT = 2'd3;

  localparam logic [7:0] CMD_ARRAY_MODE = 8'hFF;
  localparam logic [7:0] CMD_STATUS = 8'h70;
  localparam logic [7:0] CMD_READ_ID = 8'h90;
  localparam logic [7:0] CMD_BLOCK_ERASE = 8'h20;
  localparam logic [7:0] CMD_PROGRAM = 8'h40;
  localparam logic [7:0] CMD_PROGRAM_ALT = 8'h10;
  localparam logic [7:0] CMD_STATUS_CLR = 8'h50;
  localparam logic [7:0] CMD_ERASE_GO = 8'hD0;

  localparam logic [7:0] MFR_ID = 8'h89;
  localparam logic [7:0] STATUS_READY = 8'h80;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  localparam logic [15:0] ID_2M_WORD_BOTTOM = 16'h2275;
  localparam logic [15:0] ID_2M_WORD_TOP = 16'h2274;
  localparam logic [15:0] ID_2M_BYTE_BOTTOM = 16'h007D;
  localparam logic [15:0] ID_2M_BYTE_TOP = 16'h007C;
  localparam logic [15:0] ID_1M_BOTTOM = 16'h0095;
  localparam logic [15:0] ID_1M_TOP = 16'h0094;

  localparam logic [ADDR_W-1:0] MASK_LARGE = 18'h3FFFF;
  localparam logic [ADDR_W-1:0] MASK_SMALL = 18'h1FFFF;
  localparam logic [ADDR_W-1:0] A16_BIT = 18'h10000;
  localparam logic [ADDR_W-1:0] BOOT_MASK_SMALL = 18'h3E000;
  localparam logic [ADDR_W-1:0] BOOT_MASK_LARGE = 18'h3C000;
  localparam logic [ADDR_W-1:0] BOOT_TOP_SMALL = 18'h1E000;
  localparam logic [ADDR_W-1:0] BOOT_TOP_LARGE = 18'h3C000;

  typedef struct packed {
    logic word_mode;
    logic invert_a16;
    logic bottom_boot;
    logic two_megabit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [17:0] address;
    logic        wide;
    logic [15:0] write_data;
  } req_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  status_now;
  } rsp_item_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } blk_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              wide;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] addr1;
    logic [15:0]       val;
    logic              in_boot;
    logic              blk_hit;
    logic [ADDR_W-1:0] blk_lo;
    logic [ADDR_W-1:0] blk_hi;
  } q_entry_t;

  function automatic logic [15:0] device_id(input cfg_t c);
    logic [15:0] id;
    if (c.two_megabit) begin
      if (c.word_mode) begin
        id = c.bottom_boot ? ID_2M_WORD_BOTTOM : ID_2M_WORD_TOP;
      end else begin
        id = c.bottom_boot ? ID_2M_BYTE_BOTTOM : ID_2M_BYTE_TOP;
      end
    end else begin
      id = c.bottom_boot ? ID_1M_BOTTOM : ID_1M_TOP;
    end
    return id;
  endfunction

  // Erasable blocks by index: main 1, main 2 (2-Mbit parts only), data 1, data 2.
  function automatic blk_t blk_range(input logic m, input logic b, input logic [1:0] k);
    blk_t r;
    r.ok = 1'b1;
    r.lo = '0;
    r.hi = '0;
    case ({m, b, k})
      4'b0000: begin r.lo = 18'h00000; r.hi = 18'h1BFFF; end
      4'b0010: begin r.lo = 18'h1C000; r.hi = 18'h1CFFF; end
      4'b0011: begin r.lo = 18'h1D000; r.hi = 18'h1DFFF; end
      4'b0100: begin r.lo = 18'h04000; r.hi = 18'h1FFFF; end
      4'b0110: begin r.lo = 18'h02000; r.hi = 18'h02FFF; end
      4'b0111: begin r.lo = 18'h03000; r.hi = 18'h03FFF; end
      4'b1000: begin r.lo = 18'h00000; r.hi = 18'h1FFFF; end
      4'b1001: begin r.lo = 18'h20000; r.hi = 18'h37FFF; end
      4'b1010: begin r.lo = 18'h38000; r.hi = 18'h39FFF; end
      4'b1011: begin r.lo = 18'h3A000; r.hi = 18'h3BFFF; end
      4'b1100: begin r.lo = 18'h20000; r.hi = 18'h3FFFF; end
      4'b1101: begin r.lo = 18'h08000; r.hi = 18'h1FFFF; end
      4'b1110: begin r.lo = 18'h06000; r.hi = 18'h07FFF; end
      4'b1111: begin r.lo = 18'h04000; r.hi = 18'h05FFF; end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/boot_block_flash_command_interface.sv]
// The front end queues items while the back end is busy. The back end works through one
// item at a time: ID and status reads answer from registers, array reads go through the
// single read port of the array, a word program writes its two bytes one after the other,
// and an erase confirm writes 0xFF to every byte of the block. Reset clears the control
// state and then sweeps the array to 0xFF; no item is accepted during the sweep.
`default_nettype none

module boot_block_flash_command_interface #(
  parameter int ARRAY_BYTES = bbfci_pkg::ARRAY_BYTES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire bbfci_pkg::req_item_t                req,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output bbfci_pkg::rsp_item_t                     rsp,
  input  wire logic                                cfg_write,
  input  wire logic [bbfci_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic                                cfg_data
);
  import bbfci_pkg::*;

  cfg_t     cfg;
  q_entry_t entry;
  q_entry_t q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_valid;
  logic     clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WORD_MODE:   cfg.word_mode <= cfg_data;
        REG_INVERT_A16:  cfg.invert_a16 <= cfg_data;
        REG_BOTTOM_BOOT: cfg.bottom_boot <= cfg_data;
        REG_TWO_MEGABIT: cfg.two_megabit <= cfg_data;
        default:         cfg <= cfg;
      endcase
    end
  end

  bbfci_front u_front (
    .req_valid(req_valid),
    .req      (req),
    .cfg      (cfg),
    .q_full   (q_full),
    .clearing (clearing),
    .req_stall(req_stall),
    .q_push   (q_push),
    .entry    (entry)
  );

  bbfci_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  bbfci_back #(
    .ARRAY_BYTES(ARRAY_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

[hdl/bbfci_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bbfci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/bbfci_front.sv]
// Front end: accepts request items, maps the address and classifies the item.
// Also looks up the erase block and the boot block flag. Depends on bbfci_pkg.
`default_nettype none

module bbfci_front (
  input  wire logic                 req_valid,
  input  wire bbfci_pkg::req_item_t req,
  input  wire bbfci_pkg::cfg_t      cfg,
  input  wire logic                 q_full,
  input  wire logic                 clearing,
  output logic                      req_stall,
  output logic                      q_push,
  output bbfci_pkg::q_entry_t       entry
);
  import bbfci_pkg::*;

  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] boot_mask;
  logic [ADDR_W-1:0] boot_base;
  logic [ADDR_W-1:0] mapped;
  logic [ADDR_W-1:0] a_eff;
  blk_t              blk;

  assign req_stall = q_full || clearing;
  assign q_push = req_valid && !req_stall;

  always_comb begin
    mask = cfg.two_megabit ? MASK_LARGE : MASK_SMALL;
    boot_mask = cfg.two_megabit ? BOOT_MASK_LARGE : (BOOT_MASK_SMALL & mask);
    if (cfg.bottom_boot) begin
      boot_base = '0;
    end else begin
      boot_base = cfg.two_megabit ? BOOT_TOP_LARGE : BOOT_TOP_SMALL;
    end
    mapped = (req.address ^ (cfg.invert_a16 ? A16_BIT : '0)) & mask;
    if (req.opcode == OP_READ && req.wide && cfg.word_mode) begin
      a_eff = {mapped[ADDR_W-1:1], 1'b0};
    end else begin
      a_eff = mapped;
    end

    entry.addr = a_eff;
    entry.addr1 = (a_eff + ADDR_W'(1)) & mask;
    entry.wide = req.wide;
    entry.in_boot = (a_eff & boot_mask) == (boot_base & boot_mask);
    entry.val = req.wide ? req.write_data : {8'h00, req.write_data[7:0]};

    case (req.opcode)
      OP_READ:    entry.kind = KIND_READ;
      OP_WRITE:   entry.kind = (req.wide && !cfg.word_mode) ? KIND_NOP : KIND_WRITE;
      OP_PRELOAD: entry.kind = KIND_PRELOAD;
      default:    entry.kind = KIND_NOP;
    endcase

    entry.blk_hit = 1'b0;
    entry.blk_lo = '0;
    entry.blk_hi = '0;
    for (int k = 0; k < 4; k++) begin
      blk = blk_range(cfg.two_megabit, cfg.bottom_boot, 2'(k));
      if (blk.ok && a_eff >= blk.lo && a_eff <= blk.hi) begin
        entry.blk_hit = 1'b1;
        entry.blk_lo = blk.lo;
        entry.blk_hi = blk.hi;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bbfci_queue.sv]
// Short queue of classified items between the front end and the back end.
// Depends on bbfci_pkg.
`default_nettype none

module bbfci_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bbfci_pkg::q_entry_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output bbfci_pkg::q_entry_t      head
);
  import bbfci_pkg::*;

  q_entry_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr;
  logic [QUEUE_PTR_W-1:0] rptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full = count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bbfci_back.sv]
// Back end: runs the command protocol, the array accesses and the erase sweep.
// Holds the command, status, program address and the result register.
// Depends on bbfci_pkg and bbfci_ram.
`default_nettype none

module bbfci_back #(
  parameter int ARRAY_BYTES = bbfci_pkg::ARRAY_BYTES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bbfci_pkg::cfg_t     cfg,
  input  wire logic                q_valid,
  input  wire bbfci_pkg::q_entry_t q_head,
  output logic                     q_pop,
  output logic                     clearing,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output bbfci_pkg::rsp_item_t     rsp
);
  import bbfci_pkg::*;

  localparam int AW = $clog2(ARRAY_BYTES);
  localparam logic [ADDR_W:0] ABYTES = (ADDR_W+1)'(ARRAY_BYTES);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(ARRAY_BYTES - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_RD0 = 4'd3;
  localparam logic [3:0] S_RD1 = 4'd4;
  localparam logic [3:0] S_RD2 = 4'd5;
  localparam logic [3:0] S_PROG1 = 4'd6;
  localparam logic [3:0] S_ERASE = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state;
  logic [ADDR_W-1:0] ptr;
  q_entry_t          cur;
  logic [7:0]        cmd;
  logic [7:0]        status;
  logic [ADDR_W-1:0] pend;
  logic [15:0]       res;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;
  logic              prog_ok;
  logic              is_prog;
  logic              can_load;
  logic [15:0]       id;

  function automatic logic [AW-1:0] array_index(input logic [ADDR_W-1:0] x);
    logic [ADDR_W:0] xe;
    xe = {1'b0, x};
    if (xe >= ABYTES) begin
      xe = xe - ABYTES;
    end
    return xe[AW-1:0];
  endfunction

  bbfci_ram #(
    .WIDTH(8),
    .DEPTH(ARRAY_BYTES)
  ) u_array (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign clearing = state == S_CLEAR;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign can_load = !rsp_valid || !rsp_stall;
  assign id = device_id(cfg);
  assign is_prog = cmd == CMD_PROGRAM || cmd == CMD_PROGRAM_ALT;
  assign prog_ok = !cur.in_boot && cur.addr == pend;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = array_index(cur.addr);
    ram_wdata = cur.val[7:0];
    ram_raddr = (state == S_RD1) ? array_index(cur.addr1) : array_index(cur.addr);
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = ERASED_BYTE;
      end
      S_ERASE: begin
        ram_we = 1'b1;
        ram_waddr = array_index(ptr);
        ram_wdata = ERASED_BYTE;
      end
      S_EXEC: begin
        ram_we = (cur.kind == KIND_PRELOAD) || (cur.kind == KIND_WRITE && is_prog && prog_ok);
      end
      S_PROG1: begin
        ram_we = 1'b1;
        ram_waddr = array_index(cur.addr1);
        ram_wdata = cur.val[15:8];
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      cmd <= CMD_ARRAY_MODE;
      status <= '0;
      pend <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            res <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (cur.kind)
            KIND_READ: begin
              if (!cur.wide && cmd == CMD_READ_ID) begin
                res <= cur.addr[0] ? {8'h00, id[7:0]} : {8'h00, MFR_ID};
              end else if (!cur.wide && cmd == CMD_STATUS) begin
                res <= {8'h00, status};
              end else if (cur.wide && cfg.word_mode && cmd == CMD_READ_ID) begin
                res <= cur.addr[1] ? id : {8'h00, MFR_ID};
              end else if (cur.wide && cfg.word_mode && cmd == CMD_STATUS) begin
                res <= {8'h00, status};
              end else begin
                state <= S_RD0;
              end
            end
            KIND_WRITE: begin
              if (cmd == CMD_BLOCK_ERASE) begin
                cmd <= CMD_STATUS;
                if (cur.val == {8'h00, CMD_ERASE_GO}) begin
                  status <= STATUS_READY;
                  if (cur.blk_hit) begin
                    ptr <= cur.blk_lo;
                    state <= S_ERASE;
                  end
                end
              end else if (is_prog) begin
                cmd <= CMD_STATUS;
                status <= STATUS_READY;
                if (prog_ok && cur.wide) begin
                  state <= S_PROG1;
                end
              end else begin
                cmd <= cur.val[7:0];
                if (cur.val == {8'h00, CMD_STATUS_CLR}) begin
                  status <= '0;
                end else if (cur.val == {8'h00, CMD_PROGRAM} ||
                             cur.val == {8'h00, CMD_PROGRAM_ALT}) begin
                  pend <= cur.addr;
                end
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          res[7:0] <= ram_rdata;
          state <= cur.wide ? S_RD2 : S_DONE;
        end
        S_RD2: begin
          res[15:8] <= ram_rdata;
          state <= S_DONE;
        end
        S_PROG1: state <= S_DONE;
        S_ERASE: begin
          ptr <= ptr + 1'b1;
          if (ptr == cur.blk_hi) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && can_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && can_load) begin
      rsp.read_data <= res;
      rsp.status_now <= status;
    end
  end

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped outside idle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && can_load) |=> state == S_IDLE && rsp_valid)
    else $error("result not loaded when leaving done");

  a_erase_writes_ones: assert property (@(posedge clk) disable iff (rst)
    state == S_ERASE |-> ram_we && ram_wdata == ERASED_BYTE)
    else $error("erase sweep not writing erased bytes");

  a_erase_in_block: assert property (@(posedge clk) disable iff (rst)
    state == S_ERASE |-> ptr >= cur.blk_lo && ptr <= cur.blk_hi)
    else $error("erase pointer outside block");

endmodule

`default_nettype wire
